@@ src/hsv_to_rgb_converter_assert.svh @@
// assertion macros for the hsv to rgb converter
// used by the pipeline stage modules, expects clk and arst_n in scope
`ifndef HSV_TO_RGB_CONVERTER_ASSERT_SVH
`define HSV_TO_RGB_CONVERTER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define HSV_ASSERT_NOW(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define HSV_ASSERT_NEXT(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

@@ src/hsv2rgb_pkg.sv @@
// types and constants shared by the hsv to rgb converter pipeline
// no dependencies
package hsv2rgb_pkg;

	localparam logic [12:0] HUE_FULL   = 13'd5760;
	localparam logic [12:0] HUE_SECTOR = 13'd960;
	localparam logic [7:0]  UNIT       = 8'd255;

	// ceil(2^24 / 255), exact for dividends up to 255*255
	localparam logic [16:0] P_RECIP = 17'd65794;
	// ceil(2^32 / 3825), exact for dividends up to 255*255*960/64
	localparam logic [20:0] D_RECIP = 21'd1122868;

	typedef enum logic [2:0] {
		SEC_RY = 3'd0,
		SEC_YG = 3'd1,
		SEC_GC = 3'd2,
		SEC_CB = 3'd3,
		SEC_BM = 3'd4,
		SEC_MR = 3'd5
	} sector_t;

	typedef struct packed {
		logic [12:0] hue;
		logic [7:0]  saturation;
		logic [7:0]  brightness;
	} hsv_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} rgb_t;

	typedef struct packed {
		sector_t     sector;
		logic        gray;
		logic [7:0]  v;
		logic [9:0]  rem;
		logic [15:0] vs;
		logic [15:0] vns;
	} stage1_t;

	typedef struct packed {
		sector_t     sector;
		logic        gray;
		logic [7:0]  v;
		logic [7:0]  p;
		logic [25:0] drop_q;
		logic [25:0] drop_t;
	} stage2_t;

	typedef struct packed {
		sector_t    sector;
		logic       gray;
		logic [7:0] v;
		logic [7:0] p;
		logic [7:0] q;
		logic [7:0] t;
	} stage3_t;

endpackage

@@ src/hsv2rgb_sector.sv @@
// stage 1: out-of-range hue forced to zero, sector and remainder, v*s and v*(255-s) products
// depends on hsv2rgb_pkg and hsv_to_rgb_converter_assert.svh
`include "hsv_to_rgb_converter_assert.svh"

module hsv2rgb_sector (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                up_valid,
	input  hsv2rgb_pkg::hsv_t   up_data,
	output logic                up_ready,
	output logic                valid_s1,
	output hsv2rgb_pkg::stage1_t data_s1,
	input  logic                down_ready
);

	logic [12:0] hue_w;
	logic [12:0] base;
	hsv2rgb_pkg::sector_t sector;
	hsv2rgb_pkg::stage1_t next;

	assign up_ready = !valid_s1 || down_ready;

	always_comb begin
		hue_w = (up_data.hue >= hsv2rgb_pkg::HUE_FULL) ? 13'd0 : up_data.hue;
		priority if (hue_w < 13'(1 * hsv2rgb_pkg::HUE_SECTOR)) begin
			sector = hsv2rgb_pkg::SEC_RY;
			base   = 13'd0;
		end else if (hue_w < 13'(2 * hsv2rgb_pkg::HUE_SECTOR)) begin
			sector = hsv2rgb_pkg::SEC_YG;
			base   = 13'(1 * hsv2rgb_pkg::HUE_SECTOR);
		end else if (hue_w < 13'(3 * hsv2rgb_pkg::HUE_SECTOR)) begin
			sector = hsv2rgb_pkg::SEC_GC;
			base   = 13'(2 * hsv2rgb_pkg::HUE_SECTOR);
		end else if (hue_w < 13'(4 * hsv2rgb_pkg::HUE_SECTOR)) begin
			sector = hsv2rgb_pkg::SEC_CB;
			base   = 13'(3 * hsv2rgb_pkg::HUE_SECTOR);
		end else if (hue_w < 13'(5 * hsv2rgb_pkg::HUE_SECTOR)) begin
			sector = hsv2rgb_pkg::SEC_BM;
			base   = 13'(4 * hsv2rgb_pkg::HUE_SECTOR);
		end else begin
			sector = hsv2rgb_pkg::SEC_MR;
			base   = 13'(5 * hsv2rgb_pkg::HUE_SECTOR);
		end
		next.sector = sector;
		next.gray   = (up_data.saturation == 8'd0);
		next.v      = up_data.brightness;
		next.rem    = 10'(hue_w - base);
		next.vs     = 16'(up_data.brightness) * 16'(up_data.saturation);
		next.vns    = 16'(up_data.brightness) * 16'(hsv2rgb_pkg::UNIT - up_data.saturation);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (up_ready) begin
			valid_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			data_s1 <= next;
		end
	end

	`HSV_ASSERT_NOW(a_rem_range, valid_s1, data_s1.rem < 10'(hsv2rgb_pkg::HUE_SECTOR), "remainder out of sector")
	`HSV_ASSERT_NOW(a_sector_range, valid_s1, data_s1.sector <= hsv2rgb_pkg::SEC_MR, "sector out of range")

endmodule

@@ src/hsv2rgb_product.sv @@
// stage 2: scaled drops v*s*rem and v*s*(960-rem), p by reciprocal of 255
// depends on hsv2rgb_pkg and hsv_to_rgb_converter_assert.svh
`include "hsv_to_rgb_converter_assert.svh"

module hsv2rgb_product (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 valid_s1,
	input  hsv2rgb_pkg::stage1_t data_s1,
	output logic                 up_ready,
	output logic                 valid_s2,
	output hsv2rgb_pkg::stage2_t data_s2,
	input  logic                 down_ready
);

	logic [32:0] p_prod;
	logic [9:0]  rem_c;
	hsv2rgb_pkg::stage2_t next;

	assign up_ready = !valid_s2 || down_ready;

	always_comb begin
		rem_c       = 10'(hsv2rgb_pkg::HUE_SECTOR - 13'(data_s1.rem));
		p_prod      = 33'(data_s1.vns) * 33'(hsv2rgb_pkg::P_RECIP);
		next.sector = data_s1.sector;
		next.gray   = data_s1.gray;
		next.v      = data_s1.v;
		next.p      = p_prod[31:24];
		next.drop_q = 26'(data_s1.vs) * 26'(data_s1.rem);
		next.drop_t = 26'(data_s1.vs) * 26'(rem_c);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (up_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && valid_s1) begin
			data_s2 <= next;
		end
	end

	`HSV_ASSERT_NOW(a_p_bound, valid_s2, data_s2.p <= data_s2.v, "p above value")

endmodule

@@ src/hsv2rgb_divide.sv @@
// stage 3: divide the drops by 255*960 via reciprocal, form q and t
// depends on hsv2rgb_pkg and hsv_to_rgb_converter_assert.svh
`include "hsv_to_rgb_converter_assert.svh"

module hsv2rgb_divide (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 valid_s2,
	input  hsv2rgb_pkg::stage2_t data_s2,
	output logic                 up_ready,
	output logic                 valid_s3,
	output hsv2rgb_pkg::stage3_t data_s3,
	input  logic                 down_ready
);

	logic [40:0] q_prod;
	logic [40:0] t_prod;
	hsv2rgb_pkg::stage3_t next;

	assign up_ready = !valid_s3 || down_ready;

	// x / 244800 == (x >> 6) / 3825
	always_comb begin
		q_prod      = 41'(data_s2.drop_q[25:6]) * 41'(hsv2rgb_pkg::D_RECIP);
		t_prod      = 41'(data_s2.drop_t[25:6]) * 41'(hsv2rgb_pkg::D_RECIP);
		next.sector = data_s2.sector;
		next.gray   = data_s2.gray;
		next.v      = data_s2.v;
		next.p      = data_s2.p;
		next.q      = data_s2.v - q_prod[39:32];
		next.t      = data_s2.v - t_prod[39:32];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (up_ready) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && valid_s2) begin
			data_s3 <= next;
		end
	end

	`HSV_ASSERT_NOW(a_qt_bound, valid_s3, (data_s3.q <= data_s3.v) && (data_s3.t <= data_s3.v), "q or t above value")

endmodule

@@ src/hsv_to_rgb_converter.sv @@
// hsv to rgb pixel converter, four register stages, one pixel per cycle while rgb_stall is low
// a pixel passes through the sector, product and divide stage registers and then the output register
// throughput: 1 pixel per cycle while rgb_stall is low, every stage takes a new pixel while the next one moves
// each stage advances on its own, so bubbles close up under output stall
// reset clears the stage valid bits only, no clearing pass
`include "hsv_to_rgb_converter_assert.svh"

module hsv_to_rgb_converter (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              hsv_valid,
	output logic              hsv_stall,
	input  hsv2rgb_pkg::hsv_t hsv,
	output logic              rgb_valid,
	input  logic              rgb_stall,
	output hsv2rgb_pkg::rgb_t rgb
);

	logic                 ready_s1;
	logic                 ready_s2;
	logic                 ready_s3;
	logic                 ready_s4;
	logic                 valid_s1;
	logic                 valid_s2;
	logic                 valid_s3;
	hsv2rgb_pkg::stage1_t data_s1;
	hsv2rgb_pkg::stage2_t data_s2;
	hsv2rgb_pkg::stage3_t data_s3;
	hsv2rgb_pkg::rgb_t    next;

	hsv2rgb_sector u_sector (
		.clk        (clk),
		.arst_n     (arst_n),
		.up_valid   (hsv_valid),
		.up_data    (hsv),
		.up_ready   (ready_s1),
		.valid_s1   (valid_s1),
		.data_s1    (data_s1),
		.down_ready (ready_s2)
	);

	hsv2rgb_product u_product (
		.clk        (clk),
		.arst_n     (arst_n),
		.valid_s1   (valid_s1),
		.data_s1    (data_s1),
		.up_ready   (ready_s2),
		.valid_s2   (valid_s2),
		.data_s2    (data_s2),
		.down_ready (ready_s3)
	);

	hsv2rgb_divide u_divide (
		.clk        (clk),
		.arst_n     (arst_n),
		.valid_s2   (valid_s2),
		.data_s2    (data_s2),
		.up_ready   (ready_s3),
		.valid_s3   (valid_s3),
		.data_s3    (data_s3),
		.down_ready (ready_s4)
	);

	assign hsv_stall = !ready_s1;
	assign ready_s4  = !rgb_valid || !rgb_stall;

	always_comb begin
		if (data_s3.gray) begin
			next = '{red: data_s3.v, green: data_s3.v, blue: data_s3.v};
		end else begin
			unique case (data_s3.sector)
				hsv2rgb_pkg::SEC_RY: next = '{red: data_s3.v, green: data_s3.t, blue: data_s3.p};
				hsv2rgb_pkg::SEC_YG: next = '{red: data_s3.q, green: data_s3.v, blue: data_s3.p};
				hsv2rgb_pkg::SEC_GC: next = '{red: data_s3.p, green: data_s3.v, blue: data_s3.t};
				hsv2rgb_pkg::SEC_CB: next = '{red: data_s3.p, green: data_s3.q, blue: data_s3.v};
				hsv2rgb_pkg::SEC_BM: next = '{red: data_s3.t, green: data_s3.p, blue: data_s3.v};
				default:             next = '{red: data_s3.v, green: data_s3.p, blue: data_s3.q};
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rgb_valid <= 1'b0;
		end else if (ready_s4) begin
			rgb_valid <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s4 && valid_s3) begin
			rgb <= next;
		end
	end

	`HSV_ASSERT_NEXT(a_s2_hold, valid_s2 && !ready_s3, valid_s2 && $stable(data_s2), "stage 2 lost data under stall")
	`HSV_ASSERT_NEXT(a_s3_hold, valid_s3 && !ready_s4, valid_s3 && $stable(data_s3), "stage 3 lost data under stall")

endmodule
